/* rtl/weighted_random_table_select_macros.svh */
`ifndef WEIGHTED_RANDOM_TABLE_SELECT_MACROS_SVH
`define WEIGHTED_RANDOM_TABLE_SELECT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define WRTS_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed: label");

// The condition must hold in the cycle after the trigger.
`define WRTS_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed: label");

`endif

/* rtl/wrts_pkg.sv */
package wrts_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int WEIGHT_BITS = 16;
  localparam int LEVEL_W     = 16;
  localparam int FRAC_W      = 16;
  localparam int FIELD_IDX_W = 6;
  localparam int CFG_W       = 7;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int TOTAL_W     = WEIGHT_BITS + IDX_W;
  localparam int PROD_W      = FRAC_W + TOTAL_W;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [FIELD_IDX_W-1:0] entry_index;
    logic [LEVEL_W-1:0]     entry_unlock;
    logic [15:0]            entry_weight;
    logic [LEVEL_W-1:0]     current_level;
    logic [FRAC_W-1:0]      random_fraction;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [FIELD_IDX_W-1:0] chosen_index;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]     unlock;
    logic [WEIGHT_BITS-1:0] weight;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_SCALE,
    S_SEARCH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic clr_walk;
    logic sum_en;
    logic search_en;
    logic mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic hit;
    logic total_zero;
    logic out_busy;
  } status_t;

endpackage

/* rtl/weighted_random_table_select.sv */
// Weighted random selection over a table of up to 64 rows.
// Input channel (in_valid/in_ready/in_data): a write item loads one row
// (unlock level and weight); a select item brings a level and a 0.16 random
// fraction and picks a row with probability in proportion to its weight
// among rows below entries_in_use that are unlocked and have nonzero weight.
// Every item yields exactly one result item on out_valid/out_ready/out_data.
// cfg_we/cfg_wdata set entries_in_use; values above 64 saturate to 64.
// Items are handled one at a time. A write passes from acceptance through
// the finish state into the output register. A select sweeps the single
// read port of the row memory once to sum the eligible weights and once
// more to find the chosen row, with the scaling multiply between the sweeps;
// when no eligible weight is found, the second sweep is skipped.
// The result sits in an output register, so the next item is accepted while
// a finished result still waits; a stalled receiver only holds back the
// result after that. Reset clears entries_in_use and the handshake state;
// the row memory is not cleared and rows must be written before use.
`include "weighted_random_table_select_macros.svh"

module weighted_random_table_select (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wrts_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wrts_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [wrts_pkg::CFG_W-1:0]  cfg_wdata
);
  import wrts_pkg::*;

  cmd_t    cmd;
  status_t sts;

  wrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wrts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `WRTS_ASSERT_SAME(a_load_when_free, cmd.load_out, !sts.out_busy)
  `WRTS_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready)
  `WRTS_ASSERT_SAME(a_hit_needs_total, sts.hit, !sts.total_zero)
  `WRTS_ASSERT_NEXT(a_load_gives_valid, cmd.load_out, out_valid)

endmodule

/* rtl/wrts_ctrl.sv */
module wrts_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_kind,
  output logic             in_ready,
  input  wrts_pkg::status_t sts,
  output wrts_pkg::cmd_t    cmd
);
  import wrts_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == KIND_SELECT) ? S_SUM : S_FINISH;
        end
      end
      S_SUM: begin
        if (sts.walk_done) state_nxt = S_SCALE;
      end
      S_SCALE: begin
        state_nxt = sts.total_zero ? S_FINISH : S_SEARCH;
      end
      S_SEARCH: begin
        if (sts.hit || sts.walk_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.start    = in_valid;
        cmd.clr_walk = in_valid;
      end
      S_SUM:    cmd.sum_en = 1'b1;
      S_SCALE: begin
        cmd.mul      = 1'b1;
        cmd.clr_walk = 1'b1;
      end
      S_SEARCH: cmd.search_en = 1'b1;
      S_FINISH: cmd.load_out = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

/* rtl/wrts_dp.sv */
module wrts_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wrts_pkg::in_item_t          in_data,
  input  logic                        cfg_we,
  input  logic [wrts_pkg::CFG_W-1:0]  cfg_wdata,
  input  wrts_pkg::cmd_t              cmd,
  output wrts_pkg::status_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wrts_pkg::out_item_t         out_data
);
  import wrts_pkg::*;

  entry_t table_mem [MAX_ENTRIES];

  logic [CNT_W-1:0]   rows_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               pend_r;
  entry_t             rdata_r;
  logic [IDX_W-1:0]   rrow_r;
  logic [LEVEL_W-1:0] level_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] running_r;
  logic [PROD_W-1:0]  prod_r;
  logic               res_found_r;
  logic [IDX_W-1:0]   res_idx_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               issue;
  logic               elig;
  logic [TOTAL_W-1:0] wext;
  logic [TOTAL_W-1:0] run_sum;
  logic [TOTAL_W-1:0] scaled;
  logic               hit;
  logic               wr_en;

  assign issue   = (cmd.sum_en || cmd.search_en) && (cnt_r < rows_r);
  assign elig    = pend_r && (rdata_r.weight != '0) && (rdata_r.unlock <= level_r);
  assign wext    = TOTAL_W'(rdata_r.weight);
  assign run_sum = running_r + wext;
  // Fraction is 0.16 fixed point, so the integer part of the product is the target.
  assign scaled  = prod_r[PROD_W-1:FRAC_W];
  assign hit     = cmd.search_en && elig && (run_sum >= scaled);
  assign wr_en   = cmd.start && (in_data.kind == KIND_WRITE) &&
                   (32'(in_data.entry_index) < MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[IDX_W'(in_data.entry_index)] <= '{unlock: in_data.entry_unlock,
                                                  weight: WEIGHT_BITS'(in_data.entry_weight)};
    end
    if (issue) begin
      rdata_r <= table_mem[cnt_r[IDX_W-1:0]];
      rrow_r  <= cnt_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
    end else if (cfg_we) begin
      rows_r <= (32'(cfg_wdata) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.clr_walk) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      if (issue) cnt_r <= cnt_r + 1'b1;
      pend_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      level_r     <= in_data.current_level;
      frac_r      <= in_data.random_fraction;
      total_r     <= '0;
      res_found_r <= 1'b0;
      res_idx_r   <= '0;
    end else begin
      if (cmd.sum_en && elig) total_r <= total_r + wext;
      if (hit) begin
        res_found_r <= 1'b1;
        res_idx_r   <= rrow_r;
      end
    end
    if (cmd.clr_walk) begin
      running_r <= '0;
    end else if (cmd.search_en && elig) begin
      running_r <= run_sum;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(frac_r) * PROD_W'(total_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.found        <= res_found_r;
      out_data_r.chosen_index <= FIELD_IDX_W'(res_idx_r);
    end
  end

  assign sts.walk_done  = (cnt_r == rows_r) && !pend_r;
  assign sts.hit        = hit;
  assign sts.total_zero = (total_r == '0);
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import wrts_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  in_item_t               pending_items[$];
  out_item_t              expected_picks[$];
  logic [WEIGHT_BITS-1:0] row_weight [MAX_ENTRIES];
  logic [LEVEL_W-1:0]     row_unlock [MAX_ENTRIES];
  bit                     row_loaded [MAX_ENTRIES];
  int                     rows_in_use = 0;
  int                     n_queued    = 0;
  int                     n_taken     = 0;
  int                     n_errors    = 0;
  longint                 cycle_count = 0;
  int                     burst_left  = 0;
  int                     gap_left    = 0;
  int                     run_left    = 0;
  bit                     stalling    = 1'b1;

  weighted_random_table_select u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Roulette wheel over the rows in use: sum the eligible weights, scale the
  // fraction by the total and take the first row whose running sum reaches it.
  function automatic out_item_t roulette_pick(in_item_t it);
    out_item_t       pick;
    longint unsigned total;
    longint unsigned scaled;
    longint unsigned running;
    int              i;
    pick    = '0;
    total   = 0;
    running = 0;
    if (it.kind == KIND_WRITE) begin
      row_weight[it.entry_index] = it.entry_weight;
      row_unlock[it.entry_index] = it.entry_unlock;
      return pick;
    end
    for (i = 0; i < rows_in_use; i++) begin
      if (row_weight[i] != 0 && row_unlock[i] <= it.current_level) begin
        total += row_weight[i];
      end
    end
    if (total == 0) begin
      return pick;
    end
    scaled = (64'(it.random_fraction) * total) >> FRAC_W;
    for (i = 0; i < rows_in_use; i++) begin
      if (!pick.found && row_weight[i] != 0 && row_unlock[i] <= it.current_level) begin
        running += row_weight[i];
        if (running >= scaled) begin
          pick.found        = 1'b1;
          pick.chosen_index = FIELD_IDX_W'(i);
        end
      end
    end
    return pick;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternating runs of readiness and stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (run_left > 0) begin
        run_left--;
      end else begin
        stalling = !stalling;
        run_left = stalling ? $urandom_range(0, 6) : $urandom_range(0, 30);
      end
      out_ready <= !stalling;
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_picks.push_back(roulette_pick(in_data));
        n_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected result: found=%0b chosen_index=%0d", $time,
                   out_data.found, out_data.chosen_index);
          n_errors++;
        end else begin
          want = expected_picks.pop_front();
          if (out_data.found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b", $time,
                     want.found, out_data.found);
            n_errors++;
          end
          if (out_data.chosen_index !== want.chosen_index) begin
            $display("%0t: chosen_index mismatch: expected %0d, actual %0d", $time,
                     want.chosen_index, out_data.chosen_index);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_item(in_item_t it);
    if (it.kind == KIND_WRITE) begin
      row_loaded[it.entry_index] = 1'b1;
    end
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic load_row(int idx, logic [LEVEL_W-1:0] unlock, logic [15:0] weight);
    in_item_t it;
    it                 = '0;
    it.kind            = KIND_WRITE;
    it.entry_index     = FIELD_IDX_W'(idx);
    it.entry_unlock    = unlock;
    it.entry_weight    = weight;
    it.current_level   = LEVEL_W'($urandom);
    it.random_fraction = FRAC_W'($urandom);
    queue_item(it);
  endtask

  task automatic ask_pick(logic [LEVEL_W-1:0] level, logic [FRAC_W-1:0] frac);
    in_item_t it;
    it                 = '0;
    it.kind            = KIND_SELECT;
    it.entry_index     = FIELD_IDX_W'($urandom);
    it.entry_unlock    = LEVEL_W'($urandom);
    it.entry_weight    = 16'($urandom);
    it.current_level   = level;
    it.random_fraction = frac;
    queue_item(it);
  endtask

  function automatic logic [15:0] any_weight();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'($urandom_range(1, 15));
      2:       return 16'($urandom);
      default: return 16'($urandom_range(16'hFFF0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] any_unlock();
    return ($urandom_range(0, 2) == 0) ? LEVEL_W'($urandom) : LEVEL_W'($urandom_range(0, 1023));
  endfunction

  // Wait until every queued item has been taken and every result checked.
  task automatic settle();
    do @(negedge clk); while (n_taken != n_queued || expected_picks.size() != 0);
  endtask

  task automatic set_rows(int v);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_in_use = (v > MAX_ENTRIES) ? MAX_ENTRIES : v;
  endtask

  task automatic random_phase(int v, int n_items);
    int rows;
    int i;
    int idx;
    logic [LEVEL_W-1:0] level;
    logic [FRAC_W-1:0]  frac;
    set_rows(v);
    rows = (v > MAX_ENTRIES) ? MAX_ENTRIES : v;
    // Every row in use must hold real data before the first select sweeps it.
    for (i = 0; i < rows; i++) begin
      if (!row_loaded[i]) begin
        load_row(i, any_unlock(), any_weight());
      end
    end
    repeat (n_items) begin
      if ($urandom_range(0, 9) < 4) begin
        if (rows > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, rows - 1);
        end else begin
          idx = $urandom_range(0, MAX_ENTRIES - 1);
        end
        load_row(idx, any_unlock(), any_weight());
      end else begin
        case ($urandom_range(0, 5))
          0:       level = '0;
          1:       level = '1;
          2:       level = LEVEL_W'($urandom);
          default: level = LEVEL_W'($urandom_range(0, 1200));
        endcase
        case ($urandom_range(0, 5))
          0:       frac = '0;
          1:       frac = '1;
          default: frac = FRAC_W'($urandom);
        endcase
        ask_pick(level, frac);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // No rows in use straight after reset, so nothing can be found.
    ask_pick(16'hFFFF, 16'hFFFF);
    load_row(63, 16'hFFFF, 16'hFFFF);
    ask_pick(16'h0000, 16'h0000);

    set_rows(4);
    load_row(0, 16'h0000, 16'h0000);
    load_row(1, 16'h0000, 16'h0001);
    load_row(2, 16'd100, 16'hFFFF);
    load_row(3, 16'hFFFF, 16'h0003);
    ask_pick(16'h0000, 16'h0000);
    ask_pick(16'h0000, 16'hFFFF);
    ask_pick(16'd100, 16'h0000);
    ask_pick(16'd100, 16'hFFFF);
    ask_pick(16'hFFFF, 16'hFFFF);
    ask_pick(16'hFFFF, 16'h8000);
    // Lock the last unlocked row, leaving nothing eligible at level zero.
    load_row(1, 16'd50, 16'h0001);
    ask_pick(16'h0000, 16'h1234);
    ask_pick(16'd49, 16'h0000);
    ask_pick(16'd50, 16'h0000);

    random_phase(64, 160);
    random_phase(127, 120);
    random_phase(0, 40);
    random_phase(1, 60);
    repeat (8) begin
      random_phase(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 24),
                   125);
    end

    settle();
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
